/* hw/rtl/drti_pkg.sv */
// drti_pkg: shared types, codes and constants of the decimal round-to-integer unit
// used by drti_ctrl, drti_datapath and decimal_round_to_integer_unit; no dependencies
`default_nettype none

package drti_pkg;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int LIMB_W    = 32;
    localparam int NUM_LIMBS = 3;
    localparam int LIMB_IDX_W = 2;
    localparam int WORD_W    = LIMB_W * NUM_LIMBS;
    localparam int FLAGS_W   = 32;
    localparam int IN_W      = 136;
    localparam int OUT_W     = 128;

    localparam logic [LIMB_IDX_W-1:0] LIMB_TOP = LIMB_IDX_W'(NUM_LIMBS - 1);
    localparam logic [LIMB_IDX_W-1:0] LIMB_BOTTOM = '0;

    // flags word layout
    localparam int SIGN_POS  = 31;
    localparam int SCALE_LSB = 16;
    localparam int SCALE_MSB = 23;
    localparam int SCALE_W   = SCALE_MSB - SCALE_LSB + 1;
    localparam logic [FLAGS_W-1:0] SIGN_MASK     = 32'h8000_0000;
    localparam logic [FLAGS_W-1:0] RESERVED_MASK = 32'h7F00_FFFF;

    // x / 10 for 32-bit x is (x * RECIP_TEN) >> RECIP_SHIFT
    localparam logic [LIMB_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT = 35;
    // 2^32 = LIMB_DIV_TEN * 10 + LIMB_MOD_TEN
    localparam logic [LIMB_W-1:0] LIMB_DIV_TEN = 32'd429496729;
    localparam int                LIMB_MOD_TEN = 6;
    localparam int                TEN          = 10;
    localparam logic [3:0]        HALF_DIGIT   = 4'd5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TRUNC  = 2'd0,
        ACT_ROUND  = 2'd1,
        ACT_FLOOR  = 2'd2,
        ACT_NEGATE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                  load;
        logic                  step;
        logic [LIMB_IDX_W-1:0] limb;
        logic                  finish;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic scale_done;
        logic out_free;
    } t_status;

    // quotient of a value below 64 by ten
    function automatic logic [2:0] div_ten_small(input logic [5:0] t);
        logic [2:0] q;
        q = '0;
        for (int k = 1; k <= 6; k++) begin
            if (t >= 6'(k * TEN)) begin
                q = 3'(k);
            end
        end
        return q;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/drti_ctrl.sv */
// drti_ctrl: sequencer of the round-to-integer unit, steps the limb divider
// per scale digit and hands the result to the output register; uses drti_pkg
`default_nettype none

module drti_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire drti_pkg::t_status i_status,
    output drti_pkg::t_cmd         o_cmd
);
    import drti_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [LIMB_IDX_W-1:0] r_limb;
    logic [LIMB_IDX_W-1:0] n_limb;
    logic                  div_active;

    // a division is needed while scale digits remain on a valid, non-negate item
    assign div_active = !(i_status.skip || i_status.scale_done);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_active) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.limb  = r_limb;
        n_limb      = r_limb;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                n_limb     = LIMB_TOP;
            end
            ST_DIV: begin
                o_cmd.step = div_active;
                if (div_active) begin
                    n_limb = (r_limb == LIMB_BOTTOM) ? LIMB_TOP : r_limb - 1'b1;
                end
            end
            ST_FIN: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                n_limb = LIMB_TOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_limb  <= LIMB_TOP;
        end else begin
            r_state <= n_state;
            r_limb  <= n_limb;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/drti_datapath.sv */
// drti_datapath: 96-bit mantissa register, limb-serial divide by ten, rounding
// increment and output register of the round-to-integer unit; uses drti_pkg
`default_nettype none

module drti_datapath #(
    parameter int MAX_SCALE = 28
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire drti_pkg::t_cmd           i_cmd,
    output drti_pkg::t_status             o_status,
    input  wire logic [drti_pkg::IN_W-1:0] i_in_data,
    output logic [drti_pkg::OUT_W-1:0]    o_out_data,
    output logic                          o_out_err,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready
);
    import drti_pkg::*;

    localparam int CNT_W = $clog2(MAX_SCALE + 1);

    // input unpacking
    logic [ACTION_W-1:0] in_action;
    logic [WORD_W-1:0]   in_word;
    logic [FLAGS_W-1:0]  in_flags;
    logic [SCALE_W-1:0]  in_scale;
    logic                in_err;

    assign in_action = i_in_data[ACTION_W-1:0];
    assign in_word   = i_in_data[ACTION_W +: WORD_W];
    assign in_flags  = i_in_data[ACTION_W + WORD_W +: FLAGS_W];
    assign in_scale  = in_flags[SCALE_MSB:SCALE_LSB];
    assign in_err    = ((in_flags & RESERVED_MASK) != '0) ||
                       (in_scale > SCALE_W'(MAX_SCALE));

    logic [LIMB_W-1:0]  r_limbs [NUM_LIMBS];
    t_action            r_action;
    logic [FLAGS_W-1:0] r_flags;
    logic               r_err;
    logic [CNT_W-1:0]   r_scale_left;
    logic [3:0]         r_rem;
    logic [3:0]         r_digit;
    logic               r_sticky;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_err;
    logic               r_out_valid;

    // one limb of the long division: {rem, limb} / 10
    logic [LIMB_W-1:0]   limb;
    logic [2*LIMB_W-1:0] prod;
    logic [LIMB_W-1:0]   q1;
    logic [LIMB_W-1:0]   r1_full;
    logic [5:0]          t_small;
    logic [2:0]          q2;
    logic [5:0]          r2_full;
    logic [LIMB_W-1:0]   q_hi;
    logic [LIMB_W-1:0]   q_limb;
    logic [3:0]          new_rem;

    always_comb begin
        limb    = r_limbs[i_cmd.limb];
        prod    = {{LIMB_W{1'b0}}, limb} * {{LIMB_W{1'b0}}, RECIP_TEN};
        q1      = LIMB_W'(prod >> RECIP_SHIFT);
        r1_full = limb - ((q1 << 3) + (q1 << 1));
        t_small = ({2'b0, r_rem} << 2) + ({2'b0, r_rem} << 1) + {2'b0, r1_full[3:0]};
        q2      = div_ten_small(t_small);
        r2_full = t_small - (({3'b0, q2} << 3) + ({3'b0, q2} << 1));
        q_hi    = {{(LIMB_W-4){1'b0}}, r_rem} * LIMB_DIV_TEN;
        q_limb  = q_hi + q1 + {{(LIMB_W-3){1'b0}}, q2};
        new_rem = r2_full[3:0];
    end

    // rounding and result assembly
    logic [WORD_W-1:0] word;
    logic              sign;
    logic              up;
    logic [WORD_W-1:0] word_inc;
    logic [OUT_W-1:0]  fin_data;

    always_comb begin
        word = {r_limbs[2], r_limbs[1], r_limbs[0]};
        sign = r_flags[SIGN_POS];
        case (r_action)
            ACT_ROUND: begin
                up = (r_digit > HALF_DIGIT) ||
                     ((r_digit == HALF_DIGIT) && (r_sticky || word[0]));
            end
            ACT_FLOOR: up = sign && (r_sticky || (r_digit != '0));
            default:   up = 1'b0;
        endcase
        word_inc = word + {{(WORD_W-1){1'b0}}, up};
        if (r_err) begin
            fin_data = '0;
        end else if (r_action == ACT_NEGATE) begin
            fin_data = {r_flags ^ SIGN_MASK, word};
        end else begin
            fin_data = {r_flags & SIGN_MASK, word_inc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_limbs[0]   <= in_word[0 +: LIMB_W];
            r_limbs[1]   <= in_word[LIMB_W +: LIMB_W];
            r_limbs[2]   <= in_word[2*LIMB_W +: LIMB_W];
            r_action     <= t_action'(in_action);
            r_flags      <= in_flags;
            r_err        <= in_err;
            r_scale_left <= in_scale[CNT_W-1:0];
            r_rem        <= '0;
            r_digit      <= '0;
            r_sticky     <= 1'b0;
        end else if (i_cmd.step) begin
            r_limbs[i_cmd.limb] <= q_limb;
            if (i_cmd.limb == LIMB_BOTTOM) begin
                // division done: its remainder is the newest discarded digit
                r_sticky     <= r_sticky || (r_digit != '0);
                r_digit      <= new_rem;
                r_rem        <= '0;
                r_scale_left <= r_scale_left - 1'b1;
            end else begin
                r_rem <= new_rem;
            end
        end
        if (i_cmd.finish) begin
            r_out_data <= fin_data;
            r_out_err  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.skip       = r_err || (r_action == ACT_NEGATE);
    assign o_status.scale_done = (r_scale_left == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_data  = r_out_data;
    assign o_out_err   = r_out_err;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hw/rtl/decimal_round_to_integer_unit.sv */
// decimal_round_to_integer_unit: top level, stream ports around drti_ctrl and
// drti_datapath; uses drti_pkg
`default_nettype none

// Rounds a 96-bit sign-magnitude decimal (mantissa / 10^scale) to an integer by
// truncate, round half to even or floor, or flips its sign for negate. One item
// is worked on at a time. The mantissa is divided by ten once per scale step,
// one 32-bit limb per cycle through a single 32x32 reciprocal multiplier, top
// limb first; negate, scale zero and bad flags skip the division.
// A finished result sits in an output register, so the next item is taken
// while it waits. Bad flags (reserved bits set or scale above MAX_SCALE) give
// a zero result with tuser high.

module decimal_round_to_integer_unit #(
    parameter int MAX_SCALE = 28
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // action, mantissa_low, mantissa_high, flags_word
    input  wire logic [drti_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // result_low, result_high, result_flags
    output logic [drti_pkg::OUT_W-1:0]       m_axis_tdata,
    // error
    output logic                             m_axis_tuser
);
    import drti_pkg::*;

    t_cmd    cmd;
    t_status status;

    drti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    drti_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .o_out_err   (m_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

/* tb/sv/decimal_round_to_integer_unit_tb.sv */
// decimal_round_to_integer_unit_tb: self-checking testbench for the decimal round-to-integer unit
// predicts each result from the accepted input transfer and compares every output transfer
// depends on drti_pkg and decimal_round_to_integer_unit only
`timescale 1ns / 100ps

module decimal_round_to_integer_unit_tb;
    import drti_pkg::*;

    localparam int MAX_SCALE_TB = 28;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        t_action            act;
        logic [63:0]        lo;
        logic [31:0]        hi;
        logic [FLAGS_W-1:0] flags;
    } dec_item_t;

    typedef struct packed {
        logic [63:0]        lo;
        logic [31:0]        hi;
        logic [FLAGS_W-1:0] flags;
        logic               err;
    } dec_result_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    dec_result_t rounded_q[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          invalid_sent = 0;
    int          cycles = 0;
    bit          quiet_mode = 1'b0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    decimal_round_to_integer_unit #(
        .MAX_SCALE(MAX_SCALE_TB)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // integral rounding of one decimal item, bit exact
    function automatic dec_result_t round_to_integral(input dec_item_t it);
        dec_result_t r;
        logic [95:0] mag;
        logic [7:0]  scale;
        logic [3:0]  last_digit;
        logic        sticky;
        logic        bump;
        logic        neg;
        r = '0;
        scale = it.flags[SCALE_MSB:SCALE_LSB];
        neg = it.flags[SIGN_POS];
        if ((it.flags & RESERVED_MASK) != '0 || scale > MAX_SCALE_TB) begin
            r.err = 1'b1;
            return r;
        end
        if (it.act == ACT_NEGATE) begin
            r.lo = it.lo;
            r.hi = it.hi;
            r.flags = it.flags ^ SIGN_MASK;
            return r;
        end
        mag = {it.hi, it.lo};
        last_digit = '0;
        sticky = 1'b0;
        for (int k = 0; k < scale; k++) begin
            if (last_digit != 0) sticky = 1'b1;
            last_digit = 4'(mag % 96'd10);
            mag = mag / 96'd10;
        end
        bump = 1'b0;
        if (it.act == ACT_ROUND) begin
            bump = (last_digit > HALF_DIGIT) ||
                   (last_digit == HALF_DIGIT && (sticky || mag[0]));
        end else if (it.act == ACT_FLOOR) begin
            bump = neg && (sticky || last_digit != 0);
        end
        if (bump) mag = mag + 96'd1;
        r.lo = mag[63:0];
        r.hi = mag[95:64];
        r.flags = it.flags & SIGN_MASK;
        return r;
    endfunction

    function automatic dec_item_t make_item(input t_action act, input logic [95:0] mag,
                                            input logic neg, input logic [7:0] scale);
        dec_item_t it;
        it.act = act;
        it.lo = mag[63:0];
        it.hi = mag[95:64];
        it.flags = '0;
        it.flags[SIGN_POS] = neg;
        it.flags[SCALE_MSB:SCALE_LSB] = scale;
        return it;
    endfunction

    function automatic logic [95:0] pow_ten(input int n);
        logic [95:0] p;
        p = 96'd1;
        for (int k = 0; k < n; k++) p = p * 96'd10;
        return p;
    endfunction

    function automatic logic [95:0] rand_mag();
        logic [95:0] m;
        m = {$urandom, $urandom, $urandom};
        // mostly shorter numbers so rounding sees small quotients too
        if ($urandom_range(99) < 60) m = m >> $urandom_range(95);
        return m;
    endfunction

    // sender side: one transfer, with random idle cycles ahead of it
    task automatic send_item(input dec_item_t it);
        while (!quiet_mode && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, it.flags, it.hi, it.lo, it.act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rounded_q.push_back(round_to_integral(it));
        items_sent++;
        if ((it.flags & RESERVED_MASK) != '0 || it.flags[SCALE_MSB:SCALE_LSB] > MAX_SCALE_TB)
            invalid_sent++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (rounded_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver side: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet_mode || ($urandom_range(99) >= 12);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        dec_result_t got;
        dec_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.lo = m_axis_tdata[63:0];
            got.hi = m_axis_tdata[95:64];
            got.flags = m_axis_tdata[127:96];
            got.err = m_axis_tuser;
            results_seen++;
            if (rounded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: hi=%h lo=%h flags=%h err=%b",
                             got.hi, got.lo, got.flags, got.err);
            end else begin
                want = rounded_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on result %0d:", results_seen);
                        $display("  expected hi=%h lo=%h flags=%h err=%b",
                                 want.hi, want.lo, want.flags, want.err);
                        $display("  actual   hi=%h lo=%h flags=%h err=%b",
                                 got.hi, got.lo, got.flags, got.err);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // extremes, every action, half-even ties, carries and bad flags
    task automatic test_directed();
        logic [95:0] all_ones;
        all_ones = '1;
        send_item(make_item(ACT_TRUNC, 96'd0, 1'b0, 8'd0));
        send_item(make_item(ACT_TRUNC, all_ones, 1'b1, 8'd0));
        send_item(make_item(ACT_TRUNC, all_ones, 1'b0, 8'd28));
        send_item(make_item(ACT_ROUND, all_ones, 1'b1, 8'd28));
        send_item(make_item(ACT_FLOOR, all_ones, 1'b1, 8'd28));
        send_item(make_item(ACT_NEGATE, all_ones, 1'b0, 8'd28));
        send_item(make_item(ACT_NEGATE, 96'd12345, 1'b1, 8'd3));
        send_item(make_item(ACT_ROUND, 96'd25, 1'b0, 8'd1));    // tie, even stays
        send_item(make_item(ACT_ROUND, 96'd35, 1'b1, 8'd1));    // tie, odd goes up
        send_item(make_item(ACT_ROUND, 96'd251, 1'b0, 8'd2));   // tie digit with nonzero tail
        send_item(make_item(ACT_ROUND, 96'd26, 1'b0, 8'd1));
        send_item(make_item(ACT_ROUND, 96'd24, 1'b0, 8'd1));
        send_item(make_item(ACT_FLOOR, 96'd201, 1'b1, 8'd2));   // only earlier digit nonzero
        send_item(make_item(ACT_FLOOR, 96'd300, 1'b1, 8'd2));   // exact, no bump
        send_item(make_item(ACT_FLOOR, 96'd301, 1'b0, 8'd2));   // positive never bumps
        send_item(make_item(ACT_TRUNC, 96'd7, 1'b1, 8'd1));     // negative zero kept
        // increments carrying into the upper limbs
        send_item(make_item(ACT_ROUND, 96'hFFFF_FFFF * 96'd10 + 96'd9, 1'b0, 8'd1));
        send_item(make_item(ACT_ROUND, 96'hFFFF_FFFF_FFFF_FFFF * 96'd10 + 96'd9, 1'b0, 8'd1));
        send_item(make_item(ACT_FLOOR, 96'hFFFF_FFFF_FFFF_FFFF * 96'd10 + 96'd1, 1'b1, 8'd1));
        send_item(make_item(ACT_TRUNC, 96'd99, 1'b0, 8'd29));   // scale above maximum
        send_item(make_item(ACT_ROUND, 96'd99, 1'b1, 8'd255));
        send_item(make_item(ACT_NEGATE, 96'd99, 1'b0, 8'd29));
        send_item('{act: ACT_NEGATE, lo: 64'd5, hi: 32'd0, flags: 32'h0000_0001});
        send_item('{act: ACT_TRUNC, lo: '1, hi: '1, flags: 32'hFFFF_FFFF});
        wait_all_results();
    endtask

    task automatic test_random_mix(input int count);
        dec_item_t it;
        logic [95:0] mag;
        int pick;
        for (int n = 0; n < count; n++) begin
            mag = rand_mag();
            pick = $urandom_range(99);
            it = make_item(t_action'($urandom_range(3)), mag, 1'($urandom),
                           8'($urandom_range(MAX_SCALE_TB)));
            if (pick < 6) begin
                it.flags[SCALE_MSB:SCALE_LSB] = 8'($urandom_range(255, MAX_SCALE_TB + 1));
            end else if (pick < 11) begin
                it.flags = it.flags | (32'd1 << $urandom_range(31)) & RESERVED_MASK;
            end else if (pick < 16) begin
                it.flags = $urandom;
            end
            send_item(it);
        end
    endtask

    // values built around the halfway point of the discarded digits
    task automatic test_ties(input int count);
        logic [95:0] quot;
        logic [95:0] unit;
        logic [95:0] tail;
        int sc;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                sc = MAX_SCALE_TB;
                quot = 96'($urandom_range(7));
            end else begin
                sc = $urandom_range(9, 1);
                quot = 96'($urandom);
            end
            unit = pow_ten(sc);
            case ($urandom_range(6))
                0: tail = unit / 96'd2;
                1: tail = unit / 96'd2 - 96'd1;
                2: tail = unit / 96'd2 + 96'd1;
                3: tail = 96'd0;
                4: tail = 96'd1;
                5: tail = unit - 96'd1;
                default: tail = 96'($urandom) % unit;
            endcase
            send_item(make_item(t_action'($urandom_range(2)), quot * unit + tail,
                                1'($urandom), 8'(sc)));
        end
    endtask

    task automatic test_no_idle(input int count);
        quiet_mode = 1'b1;
        test_random_mix(count);
        quiet_mode = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, then a full pause
    task automatic test_backpressure(input int count);
        hold_req++;
        for (int n = 0; n < count; n++)
            send_item(make_item(t_action'($urandom_range(3)), rand_mag(), 1'($urandom),
                                8'($urandom_range(4))));
        wait_all_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix(300);
        test_backpressure(40);
        test_ties(250);
        test_no_idle(150);
        test_random_mix(100);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += rounded_q.size();
        $display("sent %0d items (%0d with bad flags), checked %0d results in %0d cycles",
                 items_sent, invalid_sent, results_seen, cycles);
        $display("covered truncate, round half even, floor, negate, ties and 96-bit carries");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/drti_pkg.sv
hw/rtl/drti_ctrl.sv
hw/rtl/drti_datapath.sv
hw/rtl/decimal_round_to_integer_unit.sv
tb/sv/decimal_round_to_integer_unit_tb.sv
